// ===== rtl/core/ttt_pkg.sv =====
// Shared definitions for the time-triggered task table: operation and result codes,
// parameter defaults and the command word passed from the front end to the slot engine.
// No dependencies.
package ttt_pkg;

   localparam int DEF_TASK_SLOTS = 16;
   localparam int DEF_COUNT_BITS = 16;
   localparam int DEF_RUN_BITS   = 8;

   // Request operation codes.
   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_DELETE   = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;
   localparam logic [1:0] OP_DISPATCH = 2'd3;

   // Response kind codes.
   localparam logic [1:0] KIND_ASSIGNED = 2'd0;
   localparam logic [1:0] KIND_FULL     = 2'd1;
   localparam logic [1:0] KIND_RUN      = 2'd2;

   // One classified request as it sits in the command queue.
   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  slot;
      logic        del_ok;
      logic [15:0] period;
      logic [15:0] delay;
   } ttt_cmd_type;

endpackage

// ===== rtl/core/time_triggered_task_table.sv =====
// Time-triggered task table, top level.
// Request channel (req_*): one request is add, delete, tick or dispatch, selected by tuser.
// Response channel (rsp_*): add gives one response (slot assigned or table full),
// dispatch gives one run response per slot that owes a run, in slot order, with tlast
// on the final one; delete and tick give none.
// A delete completes as the slot engine takes it from the queue. An add leaves the
// queue, then walks the valid bits from slot 0 until it finds a free slot, or answers
// table full at the last slot. Tick and dispatch visit every slot through the table
// memory, reading one slot while the previous one is written back.
// The first response appears in the cycle after the engine decides it, from a register.
// A two-entry command queue lets requests be taken while the engine is busy.
// Reset clears all slot valid bits at once, so the table reads as empty right away;
// no clearing pass is needed.
// When the receiver stalls, the response register holds and the engine pauses on the
// slot that needs to respond; requests keep queuing until the queue fills.
// Depends on ttt_pkg, ttt_front and ttt_back.
module time_triggered_task_table #(
   parameter int TASK_SLOTS = ttt_pkg::DEF_TASK_SLOTS,
   parameter int COUNT_BITS = ttt_pkg::DEF_COUNT_BITS,
   parameter int RUN_BITS   = ttt_pkg::DEF_RUN_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // slot[3:0], period[19:4], delay[35:20], zero fill
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // task_slot[3:0], zero fill
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast
);
   import ttt_pkg::*;

   logic        cmd_valid;
   ttt_cmd_type cmd;
   logic        cmd_pop;
   logic [3:0]  rsp_slot;

   ttt_front #(
      .TASK_SLOTS(TASK_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata[35:0]),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   ttt_back #(
      .TASK_SLOTS(TASK_SLOTS),
      .COUNT_BITS(COUNT_BITS),
      .RUN_BITS  (RUN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_kind   (rsp_tuser),
      .rsp_slot   (rsp_slot),
      .rsp_last   (rsp_tlast),
      .rsp_tready (rsp_tready)
   );

   assign rsp_tdata = {4'd0, rsp_slot};

endmodule

// ===== rtl/core/ttt_front.sv =====
// Request front end: accepts requests, classifies them and holds them in a two-entry
// command queue until the slot engine takes them. Depends on ttt_pkg.
module ttt_front #(
   parameter int TASK_SLOTS = ttt_pkg::DEF_TASK_SLOTS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [35:0]         req_tdata,   // slot[3:0], period[19:4], delay[35:20]
   input  logic [1:0]          req_tuser,   // op[1:0]
   output logic                cmd_valid,
   output ttt_pkg::ttt_cmd_type cmd,
   input  logic                cmd_pop
);
   import ttt_pkg::*;

   localparam int QDEPTH = 2;

   ttt_cmd_type   q_ff [QDEPTH];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   ttt_cmd_type   new_cmd;
   logic [31:0]   slot_w;
   logic          push;
   logic          pop;

   always_comb begin
      slot_w         = 32'(req_tdata[3:0]);
      new_cmd.op     = req_tuser;
      new_cmd.slot   = req_tdata[3:0];
      new_cmd.del_ok = (slot_w < 32'(TASK_SLOTS));
      new_cmd.period = req_tdata[19:4];
      new_cmd.delay  = req_tdata[35:20];
   end

   assign req_tready = (count_ff != 2'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== rtl/core/ttt_back.sv =====
// Slot engine: owns the slot table and carries out add, delete, tick and dispatch one
// slot per cycle unless the response stage stalls, with a registered response stage. Depends on ttt_pkg.
module ttt_back #(
   parameter int TASK_SLOTS = ttt_pkg::DEF_TASK_SLOTS,
   parameter int COUNT_BITS = ttt_pkg::DEF_COUNT_BITS,
   parameter int RUN_BITS   = ttt_pkg::DEF_RUN_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  ttt_pkg::ttt_cmd_type cmd,
   output logic                 cmd_pop,
   output logic                 rsp_tvalid,
   output logic [1:0]           rsp_kind,
   output logic [3:0]           rsp_slot,
   output logic                 rsp_last,
   input  logic                 rsp_tready
);
   import ttt_pkg::*;

   localparam int IDX_BITS   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_BITS   = $clog2(TASK_SLOTS + 1);
   localparam int ENTRY_BITS = RUN_BITS + 2 * COUNT_BITS;
   localparam logic [RUN_BITS-1:0] RUN_MAX  = '1;
   localparam logic [CNT_BITS-1:0] SLOT_END = CNT_BITS'(TASK_SLOTS);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TASK_SLOTS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ADD   = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   // Entry layout: {pending runs, reload period, countdown}.
   logic [ENTRY_BITS-1:0]  slot_mem [TASK_SLOTS];
   logic [ENTRY_BITS-1:0]  rd_data_ff;

   logic [1:0]             state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [COUNT_BITS-1:0]  per_ff, per_in;
   logic [COUNT_BITS-1:0]  dly_ff, dly_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   s1_vld_ff, s1_vld_in;
   logic [IDX_BITS-1:0]    s1_idx_ff, s1_idx_in;
   logic [TASK_SLOTS-1:0]  valid_ff, valid_in;
   logic                   held_vld_ff, held_vld_in;
   logic [IDX_BITS-1:0]    held_idx_ff, held_idx_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [3:0]             rsp_slot_ff, rsp_slot_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [IDX_BITS-1:0]    cnt_idx;
   logic [31:0]            per_w, dly_w, del_w, push_w;
   logic [IDX_BITS-1:0]    del_idx;
   logic [ENTRY_BITS-1:0]  ent;
   logic [COUNT_BITS-1:0]  e_cnt, e_per;
   logic [RUN_BITS-1:0]    e_run;
   logic                   has_run;
   logic [ENTRY_BITS-1:0]  tick_entry, disp_entry;
   logic                   push_ok, stall;
   logic                   push, push_last;
   logic [1:0]             push_kind;
   logic [IDX_BITS-1:0]    push_idx;
   logic                   mem_we, rd_en;
   logic [IDX_BITS-1:0]    mem_waddr;
   logic [ENTRY_BITS-1:0]  mem_wdata;

   always_comb begin
      cnt_idx = cnt_ff[IDX_BITS-1:0];
      per_w   = 32'(cmd.period);
      dly_w   = 32'(cmd.delay);
      del_w   = 32'(cmd.slot);
      del_idx = del_w[IDX_BITS-1:0];

      // A slot that is not valid reads as all zero.
      ent     = valid_ff[s1_idx_ff] ? rd_data_ff : '0;
      e_cnt   = ent[COUNT_BITS-1:0];
      e_per   = ent[2*COUNT_BITS-1:COUNT_BITS];
      e_run   = ent[ENTRY_BITS-1:2*COUNT_BITS];
      has_run = (e_run != '0);

      if (e_cnt == '0) begin
         tick_entry = {((e_run != RUN_MAX) ? e_run + RUN_BITS'(1) : e_run), e_per, e_per};
      end else begin
         tick_entry = {e_run, e_per, e_cnt - COUNT_BITS'(1)};
      end
      disp_entry = {e_run - RUN_BITS'(1), e_per, e_cnt};

      push_ok = !rsp_vld_ff || rsp_tready;
      // Dispatch holds one found slot back so that the final response can carry last.
      stall   = s1_vld_ff && (op_ff == OP_DISPATCH) && has_run && held_vld_ff && !push_ok;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      per_in      = per_ff;
      dly_in      = dly_ff;
      cnt_in      = cnt_ff;
      s1_vld_in   = s1_vld_ff;
      s1_idx_in   = s1_idx_ff;
      valid_in    = valid_ff;
      held_vld_in = held_vld_ff;
      held_idx_in = held_idx_ff;
      cmd_pop     = 1'b0;
      push        = 1'b0;
      push_kind   = KIND_RUN;
      push_idx    = held_idx_ff;
      push_last   = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = s1_idx_ff;
      mem_wdata   = tick_entry;
      rd_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               op_in       = cmd.op;
               per_in      = per_w[COUNT_BITS-1:0];
               dly_in      = dly_w[COUNT_BITS-1:0];
               cnt_in      = '0;
               s1_vld_in   = 1'b0;
               held_vld_in = 1'b0;
               unique case (cmd.op)
                  OP_ADD: begin
                     state_in = ST_ADD;
                  end
                  OP_DELETE: begin
                     if (cmd.del_ok) begin
                        valid_in[del_idx] = 1'b0;
                     end
                  end
                  OP_TICK, OP_DISPATCH: begin
                     state_in = ST_WALK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (!valid_ff[cnt_idx]) begin
               if (push_ok) begin
                  mem_we            = 1'b1;
                  mem_waddr         = cnt_idx;
                  mem_wdata         = {{RUN_BITS{1'b0}}, per_ff, dly_ff};
                  valid_in[cnt_idx] = 1'b1;
                  push              = 1'b1;
                  push_kind         = KIND_ASSIGNED;
                  push_idx          = cnt_idx;
                  push_last         = 1'b1;
                  state_in          = ST_IDLE;
               end
            end else if (cnt_idx == LAST_IDX) begin
               if (push_ok) begin
                  push      = 1'b1;
                  push_kind = KIND_FULL;
                  push_idx  = '0;
                  push_last = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         ST_WALK: begin
            if (!stall) begin
               // Read the next slot while the previous one is updated.
               if (cnt_ff != SLOT_END) begin
                  rd_en     = 1'b1;
                  s1_vld_in = 1'b1;
                  s1_idx_in = cnt_idx;
                  cnt_in    = cnt_ff + CNT_BITS'(1);
               end else begin
                  s1_vld_in = 1'b0;
               end
               if (s1_vld_ff) begin
                  if (op_ff == OP_TICK) begin
                     if (valid_ff[s1_idx_ff]) begin
                        mem_we    = 1'b1;
                        mem_wdata = tick_entry;
                     end
                  end else if (has_run) begin
                     mem_we    = 1'b1;
                     mem_wdata = disp_entry;
                     if (e_per == '0) begin
                        valid_in[s1_idx_ff] = 1'b0;
                     end
                     if (held_vld_ff) begin
                        push = 1'b1;
                     end
                     held_vld_in = 1'b1;
                     held_idx_in = s1_idx_ff;
                  end
               end
               if ((cnt_ff == SLOT_END) && !s1_vld_ff) begin
                  state_in = (op_ff == OP_DISPATCH) ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (!held_vld_ff) begin
               state_in = ST_IDLE;
            end else if (push_ok) begin
               push        = 1'b1;
               push_last   = 1'b1;
               held_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      push_w      = 32'(push_idx);
      rsp_vld_in  = rsp_vld_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_last_in = rsp_last_ff;
      if (push) begin
         rsp_vld_in  = 1'b1;
         rsp_kind_in = push_kind;
         rsp_slot_in = push_w[3:0];
         rsp_last_in = push_last;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_vld_ff   <= 1'b0;
         valid_ff    <= '0;
         held_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_vld_ff   <= s1_vld_in;
         valid_ff    <= valid_in;
         held_vld_ff <= held_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      per_ff      <= per_in;
      dly_ff      <= dly_in;
      cnt_ff      <= cnt_in;
      s1_idx_ff   <= s1_idx_in;
      held_idx_ff <= held_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[cnt_idx];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== test/tb.sv =====
// Testbench for time_triggered_task_table: drives add, delete, tick and dispatch requests
// with random bursts and receiver stalls, and checks each response against its own slot table.
// Depends on ttt_pkg and the time_triggered_task_table RTL.
`timescale 1ns / 1ps

module tb;
   import ttt_pkg::*;

   localparam int SLOTS = DEF_TASK_SLOTS;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] task_slot;
      logic       last;
   } task_response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // slot[3:0], period[19:4], delay[35:20], zero fill
   logic [1:0]  req_tuser = '0;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // task_slot[3:0], zero fill
   logic [1:0]  rsp_tuser;        // kind[1:0]
   logic        rsp_tlast;

   // Shadow copy of the slot table.
   logic        shadow_valid [SLOTS];
   logic [15:0] shadow_count [SLOTS];
   logic [15:0] shadow_reload[SLOTS];
   logic [7:0]  shadow_runs  [SLOTS];

   task_response_type due_responses[$];

   int fail_count     = 0;
   int requests_sent  = 0;
   int responses_seen = 0;
   int full_seen      = 0;
   int runs_seen      = 0;
   int burst_left     = 0;

   logic [31:0] stall_pattern = '1;
   logic [5:0]  stall_age     = '0;

   time_triggered_task_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // Receiver readiness follows a rotating pattern that is replaced whenever stall_age wraps.
   always @(posedge clock) begin
      stall_age <= stall_age + 6'd1;
      if (stall_age == '0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern <= '1;
            1: stall_pattern <= $urandom | 32'h1;
            default: stall_pattern <= $urandom | $urandom | 32'h8000_0001;
         endcase
      end else begin
         stall_pattern <= {stall_pattern[30:0], stall_pattern[31]};
      end
      rsp_tready <= stall_pattern[0];
   end

   task automatic clear_shadow_slot(input int s);
      shadow_valid[s]  = 1'b0;
      shadow_count[s]  = '0;
      shadow_reload[s] = '0;
      shadow_runs[s]   = '0;
   endtask

   // Applies one accepted request to the shadow table and queues the responses it owes.
   task automatic advance_task_table(input logic [1:0] op, input logic [3:0] sel,
                                     input logic [15:0] per, input logic [15:0] dly);
      int                s;
      int                free_slot;
      int                final_run;
      task_response_type resp;
      case (op)
         OP_ADD: begin
            free_slot = -1;
            for (s = SLOTS - 1; s >= 0; s--)
               if (!shadow_valid[s]) free_slot = s;
            if (free_slot < 0) begin
               resp = '{kind: KIND_FULL, task_slot: 4'd0, last: 1'b1};
            end else begin
               shadow_valid[free_slot]  = 1'b1;
               shadow_reload[free_slot] = per;
               shadow_count[free_slot]  = dly;
               shadow_runs[free_slot]   = '0;
               resp = '{kind: KIND_ASSIGNED, task_slot: free_slot[3:0], last: 1'b1};
            end
            due_responses.push_back(resp);
         end
         OP_DELETE: clear_shadow_slot(int'(sel));
         OP_TICK: begin
            for (s = 0; s < SLOTS; s++) begin
               if (shadow_valid[s]) begin
                  if (shadow_count[s] == '0) begin
                     if (shadow_runs[s] != 8'hFF) shadow_runs[s] = shadow_runs[s] + 8'd1;
                     shadow_count[s] = shadow_reload[s];
                  end else begin
                     shadow_count[s] = shadow_count[s] - 16'd1;
                  end
               end
            end
         end
         default: begin
            final_run = -1;
            for (s = 0; s < SLOTS; s++)
               if (shadow_runs[s] != '0) final_run = s;
            for (s = 0; s < SLOTS; s++) begin
               if (shadow_runs[s] != '0) begin
                  shadow_runs[s] = shadow_runs[s] - 8'd1;
                  resp = '{kind: KIND_RUN, task_slot: s[3:0], last: (s == final_run)};
                  due_responses.push_back(resp);
                  if (shadow_reload[s] == '0) clear_shadow_slot(s);
               end
            end
         end
      endcase
   endtask

   // Presents one request, waits for it to be taken, then maybe leaves a gap.
   task automatic send_request(input logic [1:0] op, input logic [3:0] sel,
                               input logic [15:0] per, input logic [15:0] dly);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, dly, per, sel};
      do @(posedge clock); while (!req_tready);
      advance_task_table(op, sel, per, dly);
      requests_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      task_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (due_responses.size() == 0) begin
            $error("unexpected response: kind %0d, task_slot %0d, last %0d",
                   rsp_tuser, rsp_tdata[3:0], rsp_tlast);
            fail_count++;
         end else begin
            want = due_responses.pop_front();
            if (want.kind == KIND_FULL) full_seen++;
            if (want.kind == KIND_RUN) runs_seen++;
            if (rsp_tuser !== want.kind) begin
               $error("kind mismatch: expected %0d, actual %0d", want.kind, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[3:0] !== want.task_slot) begin
               $error("task_slot mismatch: expected %0d, actual %0d",
                      want.task_slot, rsp_tdata[3:0]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last mismatch: expected %0d, actual %0d", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Fills all sixteen slots, the first three with edge values, then one more add finds the table full.
   task automatic test_fill_table();
      int i;
      for (i = 0; i < SLOTS; i++) begin
         case (i)
            0: send_request(OP_ADD, ~i[3:0], 16'h0000, 16'h0000);
            1: send_request(OP_ADD, ~i[3:0], 16'hFFFF, 16'hFFFF);
            2: send_request(OP_ADD, ~i[3:0], 16'h5555, 16'hAAAA);
            default: send_request(OP_ADD, ~i[3:0], 16'($urandom_range(1, 6)),
                                  16'($urandom_range(0, 4)));
         endcase
      end
      send_request(OP_ADD, 4'hF, 16'h1234, 16'h0001);
   endtask

   // Deleting a free slot changes nothing, and a new add lands in the lowest free slot.
   task automatic test_delete_slots();
      send_request(OP_DELETE, 4'd15, 16'hFFFF, 16'hFFFF);
      send_request(OP_DELETE, 4'd15, 16'h0000, 16'h0000);
      send_request(OP_DELETE, 4'd0, 16'h0000, 16'h0000);
      send_request(OP_ADD, 4'd7, 16'd2, 16'd1);
      send_request(OP_ADD, 4'd0, 16'd1, 16'd0);
   endtask

   task automatic test_tick_and_dispatch();
      send_request(OP_TICK, 4'd0, 16'h0000, 16'h0000);
      send_request(OP_DISPATCH, 4'hF, 16'hFFFF, 16'hFFFF);
      send_request(OP_DISPATCH, 4'd0, 16'h0000, 16'h0000);
      repeat (3) send_request(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
      send_request(OP_DISPATCH, 4'd0, 16'h0000, 16'h0000);
   endtask

   // A run-once task that owes two runs is run once and then leaves the table.
   task automatic test_run_once();
      send_request(OP_DELETE, 4'd0, 16'h0000, 16'h0000);
      send_request(OP_ADD, 4'd0, 16'h0000, 16'h0000);
      repeat (2) send_request(OP_TICK, 4'd0, 16'h0000, 16'h0000);
      send_request(OP_DISPATCH, 4'd0, 16'h0000, 16'h0000);
      send_request(OP_DISPATCH, 4'd0, 16'h0000, 16'h0000);
   endtask

   // Mostly small periods and delays so that runs come due often; some full-width values.
   task automatic test_random_mix(input int count);
      int          pick;
      logic [15:0] per;
      logic [15:0] dly;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 9))
            0, 1: per = '0;
            7, 8, 9: per = 16'($urandom);
            default: per = 16'($urandom_range(1, 4));
         endcase
         dly = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
         if (pick < 25)
            send_request(OP_ADD, 4'($urandom), per, dly);
         else if (pick < 40)
            send_request(OP_DELETE, 4'($urandom), 16'($urandom), 16'($urandom));
         else if (pick < 78)
            send_request(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
         else
            send_request(OP_DISPATCH, 4'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      int s;
      for (s = 0; s < SLOTS; s++) clear_shadow_slot(s);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_table();
      test_delete_slots();
      test_tick_and_dispatch();
      test_run_once();
      test_random_mix(246);

      req_tvalid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Sent %0d requests; checked %0d responses (%0d run, %0d table full).",
               requests_sent, responses_seen, runs_seen, full_seen);
      if (fail_count == 0 && due_responses.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timed out with %0d responses outstanding.", due_responses.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== time_triggered_task_table.f =====
rtl/core/ttt_pkg.sv
rtl/core/ttt_front.sv
rtl/core/ttt_back.sv
rtl/core/time_triggered_task_table.sv
test/tb.sv
